### sv/irrt_pkg.sv
// Shared types, constants and codes of the I/O range reservation table.
package irrt_pkg;

    // Table geometry.
    localparam int SLOTS  = 16;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);

    // Command codes.
    localparam logic CMD_ACQUIRE = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // Resource kinds.
    localparam logic [1:0] KIND_MEM     = 2'd0;
    localparam logic [1:0] KIND_PORT    = 2'd1;
    localparam logic [1:0] KIND_DMA     = 2'd2;
    localparam logic [1:0] KIND_INVALID = 2'd3;

    // Highest DMA channel number.
    localparam logic [31:0] DMA_MAX_CHANNEL = 32'd8;

    // Result status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_BUSY = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_FINISH,
        S_REPLY
    } state_t;

    // One table entry: the range is kept as its first and last value.
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] base;
        logic [31:0] last;
    } entry_t;

    // Controls from the sequencer to the table.
    typedef struct packed {
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        entry_t            wr_entry;
        logic              clr_en;
        logic [SLOT_W-1:0] clr_addr;
        logic [SLOT_W-1:0] rd_addr;
    } tbl_ctrl_t;

endpackage

### sv/irrt_table.sv
// Reservation table storage: entry memory with registered read and valid bits.
module irrt_table (
    input  logic               aclk,
    input  logic               aresetn,
    input  irrt_pkg::tbl_ctrl_t ctrl,
    output irrt_pkg::entry_t   rd_entry,
    output logic               rd_valid
);
    import irrt_pkg::*;

    entry_t     mem [SLOTS];
    logic [SLOTS-1:0] valid_reg;
    entry_t     rd_entry_reg;
    logic       rd_valid_reg;

    // Entry memory: one write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem[ctrl.wr_addr] <= ctrl.wr_entry;
        end
        rd_entry_reg <= mem[ctrl.rd_addr];
    end

    // Valid bits are cleared by reset and by a release.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (ctrl.wr_en) begin
                valid_reg[ctrl.wr_addr] <= 1'b1;
            end
            if (ctrl.clr_en) begin
                valid_reg[ctrl.clr_addr] <= 1'b0;
            end
            rd_valid_reg <= valid_reg[ctrl.rd_addr];
        end
    end

    assign rd_entry = rd_entry_reg;
    assign rd_valid = rd_valid_reg;

endmodule

### sv/irrt_cmp.sv
// Shared overlap comparator: tests one table entry against the request.
module irrt_cmp (
    input  irrt_pkg::entry_t req,
    input  irrt_pkg::entry_t ent,
    input  logic             ent_valid,
    output logic             hit
);
    import irrt_pkg::*;

    // Inclusive interval intersection between ranges of the same kind.
    always_comb begin
        hit = ent_valid && (ent.kind == req.kind) &&
              (ent.base <= req.last) && (req.base <= ent.last);
    end

endmodule

### sv/io_range_reservation_table_unit.sv
// Top level of the I/O range reservation table: sequencer and stream ports.
//
// The block keeps SLOTS reservations of memory, I/O port and DMA ranges.
// Each input transaction on the s_ channel is one acquire or release
// request; each produces exactly one result transaction on the m_ channel.
// A release clears the slot's valid bit when accepted and answers through
// the reply state. An acquire is checked in the check state, then a single
// shared comparator walks the table one slot per cycle through the memory's
// registered read port, then the finish state commits the entry if there
// was no clash and a slot is free; the result leaves through the reply
// state. An acquire that fails the check goes from the check state straight
// to the reply state. The block takes one request at a time: s_tready is
// high only while the sequencer is idle, so a new request is taken only
// after the last one has passed its result on from the reply state. The
// result sits in an output register; if the receiver stalls, the sequencer
// holds its next result until the register is free, and a new request may
// be accepted while a result waits. A synchronous reset (aresetn low)
// empties the table at once and drops any pending result.
module io_range_reservation_table_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] command, [2:1] kind
    input  logic [2:0]  s_tuser,
    // [31:0] range_base, [63:32] range_length, [67:64] release_slot, zero pad
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] status, [5:2] granted_slot, zero pad
    output logic [7:0]  m_tdata
);
    import irrt_pkg::*;

    state_t             state_reg, state_next;
    logic               cmd_reg, cmd_next;
    logic [1:0]         kind_reg, kind_next;
    logic [31:0]        base_reg, base_next;
    logic [31:0]        len_reg, len_next;
    logic [31:0]        last_reg, last_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               clash_reg, clash_next;
    logic               found_reg, found_next;
    logic [SLOT_W-1:0]  free_reg, free_next;
    logic [1:0]         status_reg, status_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [1:0]         m_status_reg, m_status_next;
    logic [3:0]         m_slot_reg, m_slot_next;

    tbl_ctrl_t          tbl_ctrl;
    entry_t             rd_entry;
    logic               rd_valid;
    entry_t             req;
    logic               hit;
    logic [31:0]        sum;
    logic [31:0]        req_last;
    logic               req_ok;
    logic [CNT_W-1:0]   cnt_prev;
    logic [SLOT_W-1:0]  data_idx;

    irrt_table u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (tbl_ctrl),
        .rd_entry (rd_entry),
        .rd_valid (rd_valid)
    );

    assign req = '{kind: kind_reg, base: base_reg, last: last_reg};

    irrt_cmp u_cmp (
        .req       (req),
        .ent       (rd_entry),
        .ent_valid (rd_valid),
        .hit       (hit)
    );

    // Request validation on the latched fields.
    always_comb begin
        sum      = base_reg + len_reg;
        req_last = base_reg + len_reg + 32'hFFFF_FFFF;
        case (kind_reg)
            KIND_MEM:  req_ok = (sum > base_reg);
            KIND_PORT: req_ok = (base_reg[31:16] == 16'd0) && (len_reg[31:16] == 16'd0) &&
                                (sum > base_reg);
            KIND_DMA:  req_ok = (base_reg <= DMA_MAX_CHANNEL);
            default:   req_ok = 1'b0;
        endcase
    end

    // Slot index of the table data returned this cycle.
    assign cnt_prev = cnt_reg - CNT_W'(1);
    assign data_idx = cnt_prev[SLOT_W-1:0];

    // Sequencer registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Request and result payload registers.
    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        kind_reg     <= kind_next;
        base_reg     <= base_next;
        len_reg      <= len_next;
        last_reg     <= last_next;
        cnt_reg      <= cnt_next;
        clash_reg    <= clash_next;
        found_reg    <= found_next;
        free_reg     <= free_next;
        status_reg   <= status_next;
        slot_reg     <= slot_next;
        m_status_reg <= m_status_next;
        m_slot_reg   <= m_slot_next;
    end

    // Next state, table controls and result handling.
    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        kind_next     = kind_reg;
        base_next     = base_reg;
        len_next      = len_reg;
        last_next     = last_reg;
        cnt_next      = cnt_reg;
        clash_next    = clash_reg;
        found_next    = found_reg;
        free_next     = free_reg;
        status_next   = status_reg;
        slot_next     = slot_reg;
        m_status_next = m_status_reg;
        m_slot_next   = m_slot_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        tbl_ctrl          = '0;
        tbl_ctrl.rd_addr  = cnt_reg[SLOT_W-1:0];
        tbl_ctrl.wr_addr  = free_reg;
        tbl_ctrl.wr_entry = req;
        tbl_ctrl.clr_addr = SLOT_W'(s_tdata[67:64]);

        s_tready = (state_reg == S_IDLE);

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next  = s_tuser[0];
                    kind_next = s_tuser[2:1];
                    base_next = s_tdata[31:0];
                    len_next  = s_tdata[63:32];
                    if (s_tuser[0] == CMD_RELEASE) begin
                        tbl_ctrl.clr_en = (32'(s_tdata[67:64]) < SLOTS);
                        status_next     = ST_OK;
                        slot_next       = '0;
                        state_next      = S_REPLY;
                    end else begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (!req_ok) begin
                    status_next = ST_BAD;
                    slot_next   = '0;
                    state_next  = S_REPLY;
                end else begin
                    last_next  = (kind_reg == KIND_DMA) ? base_reg : req_last;
                    clash_next = 1'b0;
                    found_next = 1'b0;
                    cnt_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                cnt_next = cnt_reg + CNT_W'(1);
                // Evaluate the entry read in the previous cycle.
                if (cnt_reg != '0) begin
                    if (hit) begin
                        clash_next = 1'b1;
                    end
                    if (!rd_valid && !found_reg) begin
                        found_next = 1'b1;
                        free_next  = data_idx;
                    end
                end
                if (cnt_reg == CNT_W'(SLOTS)) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                slot_next = '0;
                if (clash_reg) begin
                    status_next = ST_BUSY;
                end else if (!found_reg) begin
                    status_next = ST_FULL;
                end else begin
                    tbl_ctrl.wr_en = 1'b1;
                    status_next    = ST_OK;
                    slot_next      = free_reg;
                end
                state_next = S_REPLY;
            end
            S_REPLY: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = status_reg;
                    m_slot_next   = 4'(slot_reg);
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, m_slot_reg, m_status_reg};

    // A commit never happens when the scan found a clash.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FINISH && clash_reg) |-> !tbl_ctrl.wr_en)
        else $error("table written despite an overlap");

    // The scan counter never runs past the table depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (cnt_reg <= CNT_W'(SLOTS)))
        else $error("scan counter out of range");

    // A granted slot is reported only with an ok status.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] == ST_OK || m_tdata[5:2] == 4'd0))
        else $error("slot reported on a failed request");

    // After a request is taken the block is busy in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request accepted back to back");

endmodule

### tb/tb_top.sv
// Self-checking testbench for the I/O range reservation table over its stream ports.
module tb_top;
    import irrt_pkg::*;

    // Run control.
    localparam int RANDOM_ITEMS     = 1730;
    localparam int QUIET_TAIL       = 200;
    localparam int LONG_HOLD_AT     = 300;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int DRAIN_EVERY      = 500;
    localparam int SETTLE_CYCLES    = 2 * (SLOTS + 4);
    localparam int CYCLE_LIMIT      = 400000;
    localparam int NUM_DIRECTED     = 24;

    // Highest port number or port count a request may carry.
    localparam logic [31:0] PORT_MAX = 32'h0000_FFFF;

    // One request as the block sees it.
    typedef struct packed {
        logic        cmd;
        logic [1:0]  kind;
        logic [31:0] base;
        logic [31:0] len;
        logic [3:0]  rslot;
    } request_t;

    // One reply as the block sends it.
    typedef struct packed {
        logic [1:0] status;
        logic [3:0] slot;
    } reply_t;

    // Directed row: request, whether the reply is written out, and that reply.
    typedef struct packed {
        request_t req;
        logic     pinned;
        reply_t   want;
    } row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [2:0]  s_tuser  = '0;
    logic [71:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;

    // Shadow copy of the reservation table.
    logic        held_valid [SLOTS];
    logic [1:0]  held_kind  [SLOTS];
    logic [31:0] held_base  [SLOTS];
    logic [31:0] held_len   [SLOTS];

    reply_t pending_replies[$];
    row_t   directed_rows [NUM_DIRECTED];
    int     error_count  = 0;
    int     cycle_count  = 0;
    int     gap_pct      = 0;
    int     stall_pct    = 0;
    logic   rx_long_hold = 1'b0;

    io_range_reservation_table_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock with a period of two time units.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Hard stop in case the block hangs.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Apply one request to the shadow table and return the reply it earns.
    function automatic reply_t reserve_outcome(input request_t req);
        reply_t      rep;
        logic [31:0] sum;
        logic [31:0] len;
        logic [32:0] req_end;
        logic [32:0] held_end;
        logic        ok;
        logic        clash;
        int          free_idx;
        rep.status = ST_OK;
        rep.slot   = '0;
        if (req.cmd == CMD_RELEASE) begin
            if (int'(req.rslot) < SLOTS)
                held_valid[req.rslot] = 1'b0;
            return rep;
        end
        // Validation comes first.
        sum = req.base + req.len;
        case (req.kind)
            KIND_MEM:  ok = sum > req.base;
            KIND_PORT: ok = req.base <= PORT_MAX && req.len <= PORT_MAX && sum > req.base;
            KIND_DMA:  ok = req.base <= DMA_MAX_CHANNEL;
            default:   ok = 1'b0;
        endcase
        if (!ok) begin
            rep.status = ST_BAD;
            return rep;
        end
        // Inclusive overlap against entries of the same kind, and the lowest free slot.
        len      = (req.kind == KIND_DMA) ? 32'd1 : req.len;
        req_end  = {1'b0, req.base} + {1'b0, len} - 33'd1;
        clash    = 1'b0;
        free_idx = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (held_valid[i]) begin
                held_end = {1'b0, held_base[i]} + {1'b0, held_len[i]} - 33'd1;
                if (held_kind[i] == req.kind && {1'b0, req.base} <= held_end &&
                    {1'b0, held_base[i]} <= req_end)
                    clash = 1'b1;
            end else if (free_idx < 0) begin
                free_idx = i;
            end
        end
        if (clash) begin
            rep.status = ST_BUSY;
        end else if (free_idx < 0) begin
            rep.status = ST_FULL;
        end else begin
            held_valid[free_idx] = 1'b1;
            held_kind[free_idx]  = req.kind;
            held_base[free_idx]  = req.base;
            held_len[free_idx]   = len;
            rep.slot             = 4'(free_idx);
        end
        return rep;
    endfunction

    // Offer one request and queue its reply once the transaction is accepted.
    task automatic offer_request(input request_t req, input logic pinned,
                                 input reply_t typed_reply);
        reply_t predicted;
        s_tvalid <= 1'b1;
        s_tuser  <= {req.kind, req.cmd};
        s_tdata  <= {4'b0000, req.rslot, req.len, req.base};
        do @(posedge aclk); while (!s_tready);
        predicted = reserve_outcome(req);
        pending_replies.push_back(pinned ? typed_reply : predicted);
    endtask

    // Result side: random stall bursts, plus one long hold on request.
    initial begin : reply_sink
        int hold;
        forever begin
            @(posedge aclk);
            if (rx_long_hold) begin
                m_tready <= 1'b0;
                for (hold = 0; hold < LONG_HOLD_CYCLES; hold++)
                    @(posedge aclk);
                rx_long_hold = 1'b0;
                m_tready <= 1'b1;
            end else if ($urandom_range(0, 99) < stall_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Compare every result transaction with the oldest queued reply.
    always @(posedge aclk) begin : reply_check
        reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_replies.size() == 0) begin
                $error("unexpected reply: status %0d, granted_slot %0d",
                       m_tdata[1:0], m_tdata[5:2]);
                error_count++;
            end else begin
                want = pending_replies.pop_front();
                if (m_tdata[1:0] !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_tdata[1:0]);
                    error_count++;
                end
                if (m_tdata[5:2] !== want.slot) begin
                    $error("granted_slot: expected %0d, actual %0d", want.slot, m_tdata[5:2]);
                    error_count++;
                end
            end
        end
    end

    // Stimulus: directed table, then random traffic in phases.
    initial begin : stimulus
        request_t req;
        int       n;
        int       pick;
        int       sub;
        int       start;
        int       acquire_pct;
        for (int i = 0; i < SLOTS; i++)
            held_valid[i] = 1'b0;

        // Rows with pinned = 0 take their reply from the shadow table.
        directed_rows = '{
            // Memory: zero length, wrap at the top, invalid kind.
            '{'{CMD_ACQUIRE, KIND_MEM,     32'h0000_0000, 32'h0000_0000, 4'd0}, 1'b1, '{ST_BAD, 4'd0}},
            '{'{CMD_ACQUIRE, KIND_MEM,     32'hFFFF_FFFF, 32'h0000_0001, 4'd0}, 1'b1, '{ST_BAD, 4'd0}},
            '{'{CMD_ACQUIRE, KIND_INVALID, 32'h0000_0000, 32'h0000_0001, 4'd0}, 1'b1, '{ST_BAD, 4'd0}},
            // Largest memory range, then a clash at its last address.
            '{'{CMD_ACQUIRE, KIND_MEM,     32'h0000_0000, 32'hFFFF_FFFF, 4'd7}, 1'b1, '{ST_OK, 4'd0}},
            '{'{CMD_ACQUIRE, KIND_MEM,     32'hFFFF_FFFE, 32'h0000_0001, 4'd0}, 1'b1, '{ST_BUSY, 4'd0}},
            // Ports: base and length beyond 16 bits, zero length, largest range.
            '{'{CMD_ACQUIRE, KIND_PORT,    32'h0001_0000, 32'h0000_0001, 4'd0}, 1'b1, '{ST_BAD, 4'd0}},
            '{'{CMD_ACQUIRE, KIND_PORT,    32'h0000_0000, 32'h0001_0000, 4'd0}, 1'b1, '{ST_BAD, 4'd0}},
            '{'{CMD_ACQUIRE, KIND_PORT,    32'h0000_0000, 32'h0000_0000, 4'd0}, 1'b1, '{ST_BAD, 4'd0}},
            '{'{CMD_ACQUIRE, KIND_PORT,    32'h0000_FFFF, 32'h0000_FFFF, 4'd0}, 1'b1, '{ST_OK, 4'd1}},
            '{'{CMD_ACQUIRE, KIND_PORT,    32'h0000_FFFE, 32'h0000_0002, 4'd0}, 1'b0, '{ST_OK, 4'd0}},
            '{'{CMD_ACQUIRE, KIND_PORT,    32'h0000_0000, 32'h0000_FFFF, 4'd0}, 1'b0, '{ST_OK, 4'd0}},
            // DMA: channel past the last, last channel, length ignored.
            '{'{CMD_ACQUIRE, KIND_DMA,     32'h0000_0009, 32'h0000_0000, 4'd0}, 1'b1, '{ST_BAD, 4'd0}},
            '{'{CMD_ACQUIRE, KIND_DMA,     32'h0000_0008, 32'h0000_0000, 4'd0}, 1'b0, '{ST_OK, 4'd0}},
            '{'{CMD_ACQUIRE, KIND_DMA,     32'h0000_0008, 32'hFFFF_FFFF, 4'd0}, 1'b0, '{ST_OK, 4'd0}},
            '{'{CMD_ACQUIRE, KIND_DMA,     32'h0000_0000, 32'hFFFF_FFFF, 4'd0}, 1'b0, '{ST_OK, 4'd0}},
            // Releases: held slot, the same slot again, a slot never used.
            '{'{CMD_RELEASE, KIND_INVALID, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd0}, 1'b1, '{ST_OK, 4'd0}},
            '{'{CMD_RELEASE, KIND_MEM,     32'h0000_0000, 32'h0000_0000, 4'd0}, 1'b1, '{ST_OK, 4'd0}},
            '{'{CMD_RELEASE, KIND_DMA,     32'h0000_0000, 32'h0000_0000, 4'd15}, 1'b1, '{ST_OK, 4'd0}},
            // Memory edges: inclusive end clashes, adjacent range fits.
            '{'{CMD_ACQUIRE, KIND_MEM,     32'h0000_1000, 32'h0000_1000, 4'd0}, 1'b0, '{ST_OK, 4'd0}},
            '{'{CMD_ACQUIRE, KIND_MEM,     32'h0000_1FFF, 32'h0000_0001, 4'd0}, 1'b0, '{ST_OK, 4'd0}},
            '{'{CMD_ACQUIRE, KIND_MEM,     32'h0000_2000, 32'h0000_0010, 4'd0}, 1'b0, '{ST_OK, 4'd0}},
            '{'{CMD_ACQUIRE, KIND_MEM,     32'hFFFF_FFFF, 32'h0000_0000, 4'd0}, 1'b1, '{ST_BAD, 4'd0}},
            '{'{CMD_ACQUIRE, KIND_PORT,    32'h0000_FFFF, 32'h0000_0001, 4'd0}, 1'b0, '{ST_OK, 4'd0}},
            '{'{CMD_RELEASE, KIND_PORT,    32'h0000_0000, 32'h0000_0000, 4'd1}, 1'b1, '{ST_OK, 4'd0}}
        };

        // Hold reset at the start, then release it.
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, with the receiver stalling now and then.
        stall_pct = 30;
        foreach (directed_rows[i])
            offer_request(directed_rows[i].req, directed_rows[i].pinned, directed_rows[i].want);
        s_tvalid <= 1'b0;
        wait (pending_replies.size() == 0);
        @(posedge aclk);

        // Random part.
        acquire_pct = 90;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            // New idling mix every hundred items; none from the first such change within the last QUIET_TAIL items.
            if (n % 100 == 0) begin
                if (n >= RANDOM_ITEMS - QUIET_TAIL) begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end else begin
                    pick      = $urandom_range(0, 2);
                    gap_pct   = (pick == 0) ? 0 : (pick == 1) ? 25 : 60;
                    pick      = $urandom_range(0, 2);
                    stall_pct = (pick == 0) ? 0 : (pick == 1) ? 25 : 60;
                end
            end
            // Every sixty items, pick at random between filling the table and thinning it out.
            if (n % 60 == 0)
                acquire_pct = $urandom_range(0, 1) ? 90 : 55;

            // Hold the result side off while requests keep coming.
            if (n == LONG_HOLD_AT) begin
                rx_long_hold = 1'b1;
                gap_pct      = 0;
            end

            // Let every queued reply come back before going on.
            if (n % DRAIN_EVERY == DRAIN_EVERY / 2) begin
                s_tvalid <= 1'b0;
                wait (pending_replies.size() == 0);
                @(posedge aclk);
            end

            if ($urandom_range(0, 99) < gap_pct) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end

            // Unused fields carry random content.
            req.cmd   = CMD_ACQUIRE;
            req.kind  = 2'($urandom);
            req.base  = $urandom;
            req.len   = $urandom;
            req.rslot = 4'($urandom);
            sub       = $urandom_range(0, 9);
            if ($urandom_range(0, 99) >= acquire_pct) begin
                // Release, mostly of a slot that is held.
                req.cmd = CMD_RELEASE;
                if ($urandom_range(0, 3) != 0) begin
                    start = $urandom_range(0, SLOTS - 1);
                    for (int k = 0; k < SLOTS; k++) begin
                        if (held_valid[(start + k) % SLOTS]) begin
                            req.rslot = 4'((start + k) % SLOTS);
                            break;
                        end
                    end
                end
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 5) begin
                    req.kind = KIND_INVALID;
                end else if (pick < 40) begin
                    // Memory: a crowded low window, the top of the space, zero length.
                    req.kind = KIND_MEM;
                    if (sub < 6) begin
                        req.base = $urandom_range(0, 4095);
                        req.len  = $urandom_range(1, 300);
                    end else if (sub < 8) begin
                        req.base = 32'hFFFF_FFFF - $urandom_range(0, 300);
                        req.len  = $urandom_range(0, 400);
                    end else if (sub == 8) begin
                        req.len = '0;
                    end
                end else if (pick < 70) begin
                    // Ports: low window, near the 16-bit limit, just beyond it.
                    req.kind = KIND_PORT;
                    if (sub < 6) begin
                        req.base = $urandom_range(0, 2047);
                        req.len  = $urandom_range(1, 128);
                    end else if (sub < 8) begin
                        req.base = PORT_MAX - $urandom_range(0, 200);
                        req.len  = $urandom_range(0, 400);
                    end else if (sub == 8) begin
                        req.base = $urandom_range(0, 32'h0001_FFFF);
                        req.len  = $urandom_range(0, 32'h0001_FFFF);
                    end
                end else begin
                    // DMA: channels around the last one, now and then far out.
                    req.kind = KIND_DMA;
                    if (sub < 9)
                        req.base = $urandom_range(0, 10);
                end
            end
            offer_request(req, 1'b0, '0);
        end

        // Wait for the last replies, then let the block settle.
        s_tvalid <= 1'b0;
        wait (pending_replies.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
